// ===== rtl/cpd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cpd_pkg;

	// Defaults for the top-level parameters.
	localparam int MAX_LEN_DEF     = 64;
	localparam int NUM_TYPES_DEF   = 4;
	localparam int FILTER_TYPE_DEF = 0;

	// Upper bound of MAX_LEN; sizes the payload count carried between modules.
	localparam int MAX_LEN_HIGH = 128;
	localparam int JOB_CNT_W    = $clog2(MAX_LEN_HIGH);

	localparam int HDR_LEN        = 4;
	localparam int HANDLER_SLOTS  = 4;
	localparam int SLOT_W         = $clog2(HANDLER_SLOTS);
	localparam int FILTER_PAYLOAD = 2;
	localparam int EXP_LEN_W      = 6;

	// Bit positions inside the filter mask and setting bytes.
	localparam int BIT_SYNC     = 0;
	localparam int BIT_SQUITTER = 1;
	localparam int BIT_RESET    = 7;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 6;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HANDLER_ENABLE = 3'd0,
		REG_EXP_LEN0       = 3'd1,
		REG_EXP_LEN1       = 3'd2,
		REG_EXP_LEN2       = 3'd3,
		REG_EXP_LEN3       = 3'd4
	} cfg_idx_t;

	typedef enum logic [2:0] {
		EV_BYTE    = 3'd0,
		EV_EMPTY   = 3'd1,
		EV_FILTER  = 3'd2,
		EV_BADHDR  = 3'd3,
		EV_UNKNOWN = 3'd4,
		EV_LENGTH  = 3'd5
	} event_t;

	typedef logic [HANDLER_SLOTS-1:0][EXP_LEN_W-1:0] exp_len_t;

	typedef struct packed {
		logic set_sync;
		logic sync_value;
		logic set_squitter;
		logic squitter_value;
		logic reset_sync;
	} filt_t;

	// Work handed from the parser to the result drain when a frame ends.
	typedef struct packed {
		logic                 valid;
		event_t               ev;
		logic [15:0]          frame_type;
		logic [JOB_CNT_W-1:0] count;
		filt_t                filt;
	} job_t;

endpackage

`default_nettype wire

// ===== rtl/cpd_payload_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cpd_payload_ram #(
	parameter int DEPTH = 60,
	parameter int AW    = 6
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/cpd_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cpd_parser #(
	parameter int MAX_LEN     = 64,
	parameter int NUM_TYPES   = 4,
	parameter int FILTER_TYPE = 0,
	parameter int AW          = 6
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          accept,
	input  wire logic                          action,
	input  wire logic [7:0]                    rx_byte,
	input  wire logic [cpd_pkg::HANDLER_SLOTS-1:0] handler_enable,
	input  wire cpd_pkg::exp_len_t             exp_len,
	output logic                               we,
	output logic      [AW-1:0]                 waddr,
	output logic      [7:0]                    wdata,
	output cpd_pkg::job_t                      job
);

	import cpd_pkg::*;

	localparam int LEN_W = $clog2(MAX_LEN + 1);
	localparam int CMP_W = 8;

	logic [LEN_W-1:0] cnt_q;
	logic [15:0]      type_q;
	logic [7:0]       len_hi_q;
	logic [LEN_W-1:0] len_q;
	logic [7:0]       mask_q;

	logic [15:0]       hdr_len;
	logic              hdr_bad;
	logic              hdr_last;
	logic              in_payload;
	logic [LEN_W-1:0]  cnt_inc;
	logic [LEN_W-1:0]  pay_idx;
	logic              pay_done;
	logic              hdr_only;
	logic [LEN_W-1:0]  fin_plen;
	logic [SLOT_W-1:0] slot;
	logic              type_unknown;
	logic              is_filter;
	logic [CMP_W-1:0]  want;
	logic              byte_in;

	assign byte_in    = accept && !action;
	assign hdr_len    = {len_hi_q, rx_byte};
	assign hdr_bad    = (hdr_len < 16'(HDR_LEN)) || (hdr_len > 16'(MAX_LEN));
	assign hdr_last   = cnt_q == LEN_W'(HDR_LEN - 1);
	assign hdr_only   = hdr_last && (hdr_len == 16'(HDR_LEN));
	assign in_payload = cnt_q >= LEN_W'(HDR_LEN);
	assign cnt_inc    = cnt_q + 1'b1;
	assign pay_idx    = cnt_q - LEN_W'(HDR_LEN);
	assign pay_done   = in_payload && (cnt_inc == len_q);
	assign fin_plen   = hdr_last ? '0 : len_q - LEN_W'(HDR_LEN);

	assign slot         = type_q[SLOT_W-1:0];
	assign type_unknown = (type_q >= 16'(NUM_TYPES)) || (type_q >= 16'(HANDLER_SLOTS)) ||
		!handler_enable[slot];
	assign is_filter    = type_q == 16'(FILTER_TYPE);
	assign want         = is_filter ? CMP_W'(FILTER_PAYLOAD) : CMP_W'(exp_len[slot]);

	assign we    = byte_in && in_payload;
	assign waddr = AW'(pay_idx);
	assign wdata = rx_byte;

	// Frame checks. A filter result is only given on the second payload byte, so the
	// setting byte is the byte of this transfer and the mask was captured before.
	always_comb begin
		job            = '0;
		job.frame_type = type_q;
		job.count      = JOB_CNT_W'(fin_plen);
		if (byte_in && hdr_last && hdr_bad) begin
			job.valid = 1'b1;
			job.ev    = EV_BADHDR;
		end else if (byte_in && (hdr_only || pay_done)) begin
			job.valid = 1'b1;
			if (type_unknown) begin
				job.ev = EV_UNKNOWN;
			end else if (CMP_W'(fin_plen) != want) begin
				job.ev = EV_LENGTH;
			end else if (is_filter) begin
				job.ev                  = EV_FILTER;
				job.filt.set_sync       = mask_q[BIT_SYNC];
				job.filt.sync_value     = mask_q[BIT_SYNC] && rx_byte[BIT_SYNC];
				job.filt.set_squitter   = mask_q[BIT_SQUITTER];
				job.filt.squitter_value = mask_q[BIT_SQUITTER] && rx_byte[BIT_SQUITTER];
				job.filt.reset_sync     = mask_q[BIT_RESET];
			end else if (fin_plen == '0) begin
				job.ev = EV_EMPTY;
			end else begin
				job.ev = EV_BYTE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			type_q   <= '0;
			len_hi_q <= '0;
			len_q    <= '0;
		end else if (accept) begin
			if (action) begin
				cnt_q    <= '0;
				type_q   <= '0;
				len_hi_q <= '0;
				len_q    <= '0;
			end else if (cnt_q < LEN_W'(2)) begin
				type_q <= {type_q[7:0], rx_byte};
				cnt_q  <= cnt_inc;
			end else if (cnt_q == LEN_W'(2)) begin
				len_hi_q <= rx_byte;
				cnt_q    <= cnt_inc;
			end else if (hdr_last) begin
				len_q <= LEN_W'(hdr_len);
				if (hdr_bad || hdr_only) begin
					cnt_q <= '0;
				end else begin
					cnt_q <= cnt_inc;
				end
			end else if (pay_done) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we && (pay_idx == '0)) begin
			mask_q <= rx_byte;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/cpd_drain.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cpd_drain #(
	parameter int AW = 6
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire cpd_pkg::job_t job,
	output logic               idle,
	output logic               re,
	output logic      [AW-1:0] raddr,
	input  wire logic [7:0]    rdata,
	output logic               res_valid,
	input  wire logic          res_ready,
	output logic      [2:0]    event_res,
	output logic      [15:0]   frame_type,
	output logic      [7:0]    data_byte,
	output logic               last,
	output logic               set_sync_filter,
	output logic               sync_filter_value,
	output logic               set_squitter_filter,
	output logic               squitter_filter_value,
	output logic               reset_sync
);

	import cpd_pkg::*;

	logic                 single_q;
	logic [JOB_CNT_W-1:0] rem_q;
	logic [AW-1:0]        raddr_q;
	logic                 rd_valid_s1;
	logic                 rd_last_s1;
	event_t               ev_q;
	logic [15:0]          type_q;
	filt_t                filt_q;

	logic                 res_valid_q;
	event_t               out_ev_q;
	logic [15:0]          out_type_q;
	logic [7:0]           out_data_q;
	logic                 out_last_q;
	filt_t                out_filt_q;

	logic out_free;
	logic move;
	logic single_go;

	assign out_free  = !res_valid_q || res_ready;
	assign move      = rd_valid_s1 && out_free;
	assign single_go = single_q && out_free;
	assign re        = (rem_q != '0) && (!rd_valid_s1 || move);
	assign raddr     = raddr_q;
	assign idle      = !single_q && (rem_q == '0) && !rd_valid_s1;

	// The read data register holds its value until the next read, so a byte
	// waiting in stage one is safe while the output register is stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			single_q    <= 1'b0;
			rem_q       <= '0;
			raddr_q     <= '0;
			rd_valid_s1 <= 1'b0;
			rd_last_s1  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (job.valid) begin
				if (job.ev == EV_BYTE) begin
					rem_q   <= job.count;
					raddr_q <= '0;
				end else begin
					single_q <= 1'b1;
				end
			end
			if (re) begin
				rem_q       <= rem_q - 1'b1;
				raddr_q     <= raddr_q + 1'b1;
				rd_valid_s1 <= 1'b1;
				rd_last_s1  <= rem_q == JOB_CNT_W'(1);
			end else if (move) begin
				rd_valid_s1 <= 1'b0;
			end
			if (single_go) begin
				single_q <= 1'b0;
			end
			if (move || single_go) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job.valid) begin
			ev_q   <= job.ev;
			type_q <= job.frame_type;
			filt_q <= job.filt;
		end
		if (move) begin
			out_ev_q   <= EV_BYTE;
			out_type_q <= type_q;
			out_data_q <= rdata;
			out_last_q <= rd_last_s1;
			out_filt_q <= '0;
		end else if (single_go) begin
			out_ev_q   <= ev_q;
			out_type_q <= type_q;
			out_data_q <= '0;
			out_last_q <= 1'b1;
			out_filt_q <= filt_q;
		end
	end

	assign res_valid             = res_valid_q;
	assign event_res             = out_ev_q;
	assign frame_type            = out_type_q;
	assign data_byte             = out_data_q;
	assign last                  = out_last_q;
	assign set_sync_filter       = out_filt_q.set_sync;
	assign sync_filter_value     = out_filt_q.sync_value;
	assign set_squitter_filter   = out_filt_q.set_squitter;
	assign squitter_filter_value = out_filt_q.squitter_value;
	assign reset_sync            = out_filt_q.reset_sync;

endmodule

`default_nettype wire

// ===== rtl/command_packet_deframer.sv =====
// Timing: a one-result frame registers its result in single_q and then in the output register;
// payload bytes pass the read counter, the memory read register and the output register, then
// one per cycle while res_ready does not hold the output. Input: one byte per cycle while a frame
// fills and the drain is idle; no new byte is taken until the drain has read out the last frame.
// Reset: arst_n clears the parser, drain and output valid; handler_enable resets to 1.
// The payload memory has no reset and is always written before it is read.
`timescale 1ns / 1ps
`default_nettype none

module command_packet_deframer #(
	parameter int MAX_LEN     = cpd_pkg::MAX_LEN_DEF,
	parameter int NUM_TYPES   = cpd_pkg::NUM_TYPES_DEF,
	parameter int FILTER_TYPE = cpd_pkg::FILTER_TYPE_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           byte_valid,
	output logic                                byte_ready,
	input  wire logic                           action,
	input  wire logic [7:0]                     rx_byte,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [cpd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [cpd_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                                res_valid,
	input  wire logic                           res_ready,
	output logic      [2:0]                     event_res,
	output logic      [15:0]                    frame_type,
	output logic      [7:0]                     data_byte,
	output logic                                last,
	output logic                                set_sync_filter,
	output logic                                sync_filter_value,
	output logic                                set_squitter_filter,
	output logic                                squitter_filter_value,
	output logic                                reset_sync
);

	import cpd_pkg::*;

	localparam int STORE_DEPTH = MAX_LEN - HDR_LEN;
	localparam int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

	logic [HANDLER_SLOTS-1:0] hen_q;
	exp_len_t                 exp_q;

	job_t          job;
	logic          drain_idle;
	logic          accept;
	logic          we;
	logic [AW-1:0] waddr;
	logic [7:0]    wdata;
	logic          re;
	logic [AW-1:0] raddr;
	logic [7:0]    rdata;

	assign cfg_ready  = 1'b1;
	assign byte_ready = drain_idle;
	assign accept     = byte_valid && byte_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hen_q <= HANDLER_SLOTS'(1);
			exp_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				REG_HANDLER_ENABLE: begin
					hen_q <= cfg_data[HANDLER_SLOTS-1:0];
				end
				REG_EXP_LEN0: begin
					exp_q[0] <= cfg_data[EXP_LEN_W-1:0];
				end
				REG_EXP_LEN1: begin
					exp_q[1] <= cfg_data[EXP_LEN_W-1:0];
				end
				REG_EXP_LEN2: begin
					exp_q[2] <= cfg_data[EXP_LEN_W-1:0];
				end
				REG_EXP_LEN3: begin
					exp_q[3] <= cfg_data[EXP_LEN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	cpd_parser #(
		.MAX_LEN    (MAX_LEN),
		.NUM_TYPES  (NUM_TYPES),
		.FILTER_TYPE(FILTER_TYPE),
		.AW         (AW)
	) u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.action        (action),
		.rx_byte       (rx_byte),
		.handler_enable(hen_q),
		.exp_len       (exp_q),
		.we            (we),
		.waddr         (waddr),
		.wdata         (wdata),
		.job           (job)
	);

	cpd_payload_ram #(
		.DEPTH(STORE_DEPTH),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	cpd_drain #(
		.AW(AW)
	) u_drain (
		.clk                  (clk),
		.arst_n               (arst_n),
		.job                  (job),
		.idle                 (drain_idle),
		.re                   (re),
		.raddr                (raddr),
		.rdata                (rdata),
		.res_valid            (res_valid),
		.res_ready            (res_ready),
		.event_res            (event_res),
		.frame_type           (frame_type),
		.data_byte            (data_byte),
		.last                 (last),
		.set_sync_filter      (set_sync_filter),
		.sync_filter_value    (sync_filter_value),
		.set_squitter_filter  (set_squitter_filter),
		.squitter_filter_value(squitter_filter_value),
		.reset_sync           (reset_sync)
	);

`ifndef SYNTH
	// The memory is never written while the drain still reads out a frame.
	a_no_write_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(re || !drain_idle) |-> !we)
		else $error("payload write while results are pending");

	a_single_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (event_res != EV_BYTE)) |-> (last && (data_byte == 8'd0)))
		else $error("non-byte result without last or with data");

	a_filter_bits: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (event_res != EV_FILTER)) |->
		!(set_sync_filter || sync_filter_value || set_squitter_filter ||
		squitter_filter_value || reset_sync))
		else $error("filter bits set on a non-filter result");

	a_job_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		job.valid |=> !drain_idle)
		else $error("frame result work lost");
`endif

endmodule

`default_nettype wire
